[design/cgt_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cgt_pkg
// Types, constants and tables shared by the calendar / GPS time converter.
// ----------------------------------------------------------------------------
package cgt_pkg;

	localparam int FRAC_BITS = 16;

	// One day in fixed-point seconds.
	localparam longint DAY_FX = 64'd86400 * (64'd1 << FRAC_BITS);

	// GPS epoch MJD plus the MJD offset of the Julian-day formula.
	localparam int CAL_DAY_OFS = 679019 + 44244;

	typedef struct packed {
		logic        req_type;
		logic [11:0] year;
		logic [3:0]  month;
		logic [4:0]  day;
		logic [4:0]  hour;
		logic [5:0]  minute;
		logic [21:0] second_fx;
		logic [12:0] gps_week;
		logic [35:0] week_seconds_fx;
	} cgt_req_t;

	typedef struct packed {
		logic [11:0] out_year;
		logic [3:0]  out_month;
		logic [4:0]  out_day;
		logic [4:0]  out_hour;
		logic [5:0]  out_minute;
		logic [21:0] out_second_fx;
		logic [2:0]  weekday;
		logic [12:0] out_week;
		logic [35:0] out_week_seconds_fx;
		logic        month_error;
	} cgt_rsp_t;

	// floor(30.6001 * k)
	function automatic logic [9:0] cgt_mterm(input logic [4:0] k);
		logic [9:0] v;
		case (k)
			5'd1:    v = 10'd30;
			5'd2:    v = 10'd61;
			5'd3:    v = 10'd91;
			5'd4:    v = 10'd122;
			5'd5:    v = 10'd153;
			5'd6:    v = 10'd183;
			5'd7:    v = 10'd214;
			5'd8:    v = 10'd244;
			5'd9:    v = 10'd275;
			5'd10:   v = 10'd306;
			5'd11:   v = 10'd336;
			5'd12:   v = 10'd367;
			5'd13:   v = 10'd397;
			5'd14:   v = 10'd428;
			5'd15:   v = 10'd459;
			5'd16:   v = 10'd489;
			5'd17:   v = 10'd520;
			5'd18:   v = 10'd550;
			5'd19:   v = 10'd581;
			5'd20:   v = 10'd612;
			default: v = 10'd0;
		endcase
		return v;
	endfunction

endpackage

[design/cgt_cal2gps.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cgt_cal2gps
// Calendar date and time to GPS week and seconds of week, five stages.
// ----------------------------------------------------------------------------
module cgt_cal2gps
	import cgt_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	input  cgt_req_t req,
	output logic     out_valid,
	output cgt_rsp_t rsp
);

	localparam logic [33:0] DAY34 = 34'(DAY_FX);

	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5;

	// stage 1: month fold, month table, hour/minute seconds
	logic               err_c;
	logic signed [12:0] y_c;
	logic [4:0]         madj_c;
	logic signed [12:0] y_s1;
	logic [9:0]         mt_s1;
	logic [4:0]         day_s1;
	logic [16:0]        hm_s1;
	logic [21:0]        sec_s1;
	logic               err_s1;

	always_comb begin
		err_c = (req.month == 4'd0) || (req.month > 4'd12);
		if (req.month < 4'd3) begin
			y_c    = $signed({1'b0, req.year} - 13'd1);
			madj_c = 5'(req.month) + 5'd12;
		end else begin
			y_c    = $signed({1'b0, req.year});
			madj_c = 5'(req.month);
		end
	end

	always_ff @(posedge clk) begin
		y_s1   <= y_c;
		mt_s1  <= cgt_mterm(madj_c + 5'd1);
		day_s1 <= req.day;
		hm_s1  <= 17'(req.hour) * 17'd3600 + 17'(req.minute) * 17'd60;
		sec_s1 <= req.second_fx;
		err_s1 <= err_c;
	end

	// stage 2: day count from the GPS epoch, fixed-point seconds of day
	logic signed [23:0] yp_c, dterm_c;
	logic [23:0]        d_s2;
	logic [33:0]        sod_s2;
	logic               err_s2;

	always_comb begin
		yp_c    = 24'(y_s1) * 24'sd1461;
		dterm_c = yp_c >>> 2;
	end

	always_ff @(posedge clk) begin
		d_s2   <= dterm_c + 24'(mt_s1) + 24'(day_s1) - 24'(CAL_DAY_OFS);
		sod_s2 <= (34'(hm_s1) << FRAC_BITS) + 34'(sec_s1);
		err_s2 <= err_s1;
	end

	// stage 3: seconds past one day carry into the day count
	logic        carry_c;
	logic [23:0] d3_c;
	logic [20:0] dn_s3;
	logic [32:0] sod_s3;
	logic        neg_s3, err_s3;

	always_comb begin
		carry_c = sod_s2 >= DAY34;
		d3_c    = d_s2 + 24'(carry_c);
	end

	always_ff @(posedge clk) begin
		dn_s3  <= d3_c[20:0];
		neg_s3 <= d3_c[23];
		sod_s3 <= carry_c ? 33'(sod_s2 - DAY34) : sod_s2[32:0];
		err_s3 <= err_s2;
	end

	// stage 4: days / 7 by reciprocal
	logic [42:0] qp_s4;
	logic [20:0] dn_s4;
	logic [32:0] sod_s4;
	logic        neg_s4, err_s4;

	always_ff @(posedge clk) begin
		qp_s4  <= 43'(dn_s3) * 43'd2396746;
		dn_s4  <= dn_s3;
		sod_s4 <= sod_s3;
		neg_s4 <= neg_s3;
		err_s4 <= err_s3;
	end

	// stage 5: week and day within week
	logic [18:0] q_c;
	logic [21:0] q7_c;
	logic [12:0] wk_s5;
	logic [2:0]  r_s5;
	logic [32:0] sod_s5;
	logic        zero_s5, err_s5;

	always_comb begin
		q_c  = qp_s4[42:24];
		q7_c = 22'(q_c) * 22'd7;
	end

	always_ff @(posedge clk) begin
		wk_s5   <= q_c[12:0];
		r_s5    <= 3'(dn_s4 - q7_c[20:0]);
		sod_s5  <= sod_s4;
		zero_s5 <= neg_s4 | err_s4;
		err_s5  <= err_s4;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
		end else begin
			vld_s1 <= in_valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
		end
	end

	always_comb begin
		rsp         = '0;
		rsp.month_error = err_s5;
		if (!zero_s5) begin
			rsp.out_week            = wk_s5;
			rsp.out_week_seconds_fx = 36'(r_s5) * 36'(DAY_FX) + 36'(sod_s5);
		end
		out_valid = vld_s5;
	end

endmodule

[design/cgt_gps2cal.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cgt_gps2cal
// GPS week and seconds of week to calendar date, time and weekday, five stages.
// ----------------------------------------------------------------------------
module cgt_gps2cal
	import cgt_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	input  cgt_req_t req,
	output logic     out_valid,
	output cgt_rsp_t rsp
);

	localparam int SEC_W = 36 - FRAC_BITS;

	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5;

	// stage 1: whole days inside the seconds of week (S / 86400 = (S >> 7) / 675)
	logic [SEC_W-1:0]     s_c;
	logic [26:0]          dqp_c;
	logic [3:0]           dq_s1;
	logic [15:0]          w7_s1;
	logic [SEC_W-1:0]     sec_s1;
	logic [FRAC_BITS-1:0] frac_s1;

	always_comb begin
		s_c   = req.week_seconds_fx[35:FRAC_BITS];
		dqp_c = 27'(s_c >> 7) * 27'd12428;
	end

	always_ff @(posedge clk) begin
		dq_s1   <= dqp_c[26:23];
		w7_s1   <= 16'(req.gps_week) * 16'd7;
		sec_s1  <= s_c;
		frac_s1 <= req.week_seconds_fx[FRAC_BITS-1:0];
	end

	// stage 2: day count, seconds of day, year-count numerator
	logic [16:0]          dayn_c;
	logic [16:0]          dayn_s2, sodi_s2;
	logic [22:0]          nc_s2;
	logic [FRAC_BITS-1:0] frac_s2;

	assign dayn_c = 17'(w7_s1) + 17'(dq_s1);

	always_ff @(posedge clk) begin
		dayn_s2 <= dayn_c;
		sodi_s2 <= 17'(21'(sec_s1) - 21'(dq_s1) * 21'd86400);
		nc_s2   <= 23'(dayn_c) * 23'd100 + 23'd31115;
		frac_s2 <= frac_s1;
	end

	// stage 3: reciprocal products
	logic [46:0]          cp_s3;
	logic [33:0]          wp_s3;
	logic [34:0]          hp_s3;
	logic [16:0]          dayn_s3, dw_s3, sodi_s3;
	logic [FRAC_BITS-1:0] frac_s3;

	always_ff @(posedge clk) begin
		cp_s3   <= 47'(nc_s2) * 47'd15051494;
		wp_s3   <= 34'(dayn_s2 + 17'd6) * 34'd149797;
		hp_s3   <= 35'(sodi_s2) * 35'd149131;
		dayn_s3 <= dayn_s2;
		dw_s3   <= dayn_s2 + 17'd6;
		sodi_s3 <= sodi_s2;
		frac_s3 <= frac_s2;
	end

	// stage 4: year count, weekday, hour, day within year
	logic [12:0]          c_c;
	logic [13:0]          wq_c;
	logic [4:0]           h_c;
	logic [23:0]          d_c;
	logic [21:0]          b_c;
	logic [12:0]          c_s4;
	logic [2:0]           wd_s4;
	logic [4:0]           h_s4;
	logic [11:0]          r1_s4;
	logic [9:0]           x_s4;
	logic [FRAC_BITS-1:0] frac_s4;

	always_comb begin
		c_c  = 13'd6695 + 13'(cp_s3[46:39]);
		wq_c = wp_s3[33:20];
		h_c  = hp_s3[33:29];
		d_c  = (24'(c_c) * 24'd1461) >> 2;
		b_c  = 22'(dayn_s3) + 22'd2445782;
	end

	always_ff @(posedge clk) begin
		c_s4    <= c_c;
		wd_s4   <= 3'(dw_s3 - 17'(wq_c) * 17'd7) + 3'd1;
		h_s4    <= h_c;
		r1_s4   <= 12'(sodi_s3 - 17'(h_c) * 17'd3600);
		x_s4    <= 10'(b_c - d_c[21:0]);
		frac_s4 <= frac_s3;
	end

	// stage 5: month index by threshold count, minute product
	logic [4:0]           e_c;
	logic [4:0]           e_s5;
	logic [24:0]          mp_s5;
	logic [9:0]           x_s5;
	logic [12:0]          c_s5;
	logic [4:0]           h_s5;
	logic [11:0]          r1_s5;
	logic [2:0]           wd_s5;
	logic [FRAC_BITS-1:0] frac_s5;

	always_comb begin
		e_c = '0;
		for (int k = 1; k <= 20; k++) begin
			if (x_s4 > cgt_mterm(5'(k)))
				e_c = e_c + 5'd1;
		end
	end

	always_ff @(posedge clk) begin
		e_s5    <= e_c;
		mp_s5   <= 25'(r1_s4) * 25'd4370;
		x_s5    <= x_s4;
		c_s5    <= c_s4;
		h_s5    <= h_s4;
		r1_s5   <= r1_s4;
		wd_s5   <= wd_s4;
		frac_s5 <= frac_s4;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
		end else begin
			vld_s1 <= in_valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
		end
	end

	// output: day, month, year, minute and seconds
	logic [3:0] mo_c;
	logic [5:0] mi_c;

	always_comb begin
		mo_c = (e_s5 >= 5'd14) ? 4'(e_s5 - 5'd13) : 4'(e_s5 - 5'd1);
		mi_c = mp_s5[23:18];
		rsp               = '0;
		rsp.out_year      = 12'(c_s5 - 13'd4715 - 13'(mo_c >= 4'd3));
		rsp.out_month     = mo_c;
		rsp.out_day       = 5'(x_s5 - cgt_mterm(e_s5));
		rsp.out_hour      = h_s5;
		rsp.out_minute    = mi_c;
		rsp.out_second_fx = {6'(r1_s5 - 12'(mi_c) * 12'd60), frac_s5};
		rsp.weekday       = wd_s5;
		out_valid         = vld_s5;
	end

endmodule

[design/calendar_gps_time_converter.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// calendar_gps_time_converter
// Done follows start through either five-stage chain and the output register.
// Throughput: one conversion per cycle; busy stays low.
// Reset clears the valid bits of both pipelines and the done strobe.
// ----------------------------------------------------------------------------
module calendar_gps_time_converter
	import cgt_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     start,
	output logic     busy,
	input  cgt_req_t req,
	output logic     done,
	output cgt_rsp_t rsp
);

	logic     cal_vld, gps_vld;
	cgt_rsp_t cal_rsp, gps_rsp;
	logic     done_q;
	cgt_rsp_t rsp_q;

	assign busy = 1'b0;

	cgt_cal2gps u_cal2gps (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (start & ~req.req_type),
		.req       (req),
		.out_valid (cal_vld),
		.rsp       (cal_rsp)
	);

	cgt_gps2cal u_gps2cal (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (start & req.req_type),
		.req       (req),
		.out_valid (gps_vld),
		.rsp       (gps_rsp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= cal_vld | gps_vld;
		end
	end

	always_ff @(posedge clk) begin
		rsp_q <= cal_vld ? cal_rsp : gps_rsp;
	end

	assign done = done_q;
	assign rsp  = rsp_q;

endmodule
